@@ rtl/core/asrd_pkg.sv @@
// Package for the audio stream ring device.
// Holds operation codes, register offsets, the controller state type and
// the command and status structs between controller and datapath.
package asrd_pkg;

  typedef enum logic [1:0] {
    OP_REG_WR  = 2'd0,
    OP_REG_RD  = 2'd1,
    OP_BUF_WR  = 2'd2,
    OP_PULL    = 2'd3
  } op_t;

  // Register byte offsets on the bus side
  localparam logic [15:0] OFF_RATE  = 16'd0;
  localparam logic [15:0] OFF_CHAN  = 16'd4;
  localparam logic [15:0] OFF_BATCH = 16'd8;
  localparam logic [15:0] OFF_SIZE  = 16'd12;
  localparam logic [15:0] OFF_INIT  = 16'd16;
  localparam logic [15:0] OFF_COUNT = 16'd20;

  // Configuration register indexes
  localparam logic [1:0] CFG_RATE  = 2'd0;
  localparam logic [1:0] CFG_CHAN  = 2'd1;
  localparam logic [1:0] CFG_BATCH = 2'd2;

  localparam int CFG_DW = 18;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WRITE  = 2'd1,
    ST_RDWAIT = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;   // take the input word
    logic wr_step;  // store one byte of a pending buffer write
    logic ld_now;   // load result computed from the input word
    logic ld_mem;   // load result from the store read port
    logic ld_wr;    // load result of a finished buffer write
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register empty or draining this cycle
    logic imm_done;   // input word completes on acceptance
    logic is_pull;    // input word is a pull
    logic wr_last;    // last byte of a buffer write is being stored
  } status_t;

endpackage

@@ rtl/core/audio_stream_ring_device.sv @@
// Audio stream ring device: register accesses, zero-length or rejected buffer
// writes and silent pulls load the result register on acceptance; a pull that
// reads the store loads it from the store read register in ST_RDWAIT; a buffer
// write loads it with its last byte, stored one per cycle via the single write port.
// One word is in flight at a time; the next is taken once the result slot drains.
// Reset clears control, pointer, count and registers; store contents stay undefined.
module audio_stream_ring_device #(
  parameter int unsigned BUF_SIZE = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [15:0]                 in_address,
  input  logic [31:0]                 in_write_data,
  input  logic [2:0]                  in_access_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_read_data,
  output logic [7:0]                  out_sample_byte,
  output logic                        out_silent,
  output logic                        out_access_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [asrd_pkg::CFG_DW-1:0] cfg_data
);

  asrd_pkg::cmd_t    cmd;
  asrd_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  asrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  asrd_datapath #(
    .BUF_SIZE (BUF_SIZE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_access_length (in_access_length),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_sample_byte  (out_sample_byte),
    .out_silent       (out_silent),
    .out_access_error (out_access_error)
  );

endmodule

@@ rtl/core/asrd_ctrl.sv @@
// Controller state machine of the audio stream ring device.
// Depends on asrd_pkg for the state type and the command/status structs.
module asrd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  asrd_pkg::status_t sts,
  output logic              in_stall,
  output asrd_pkg::cmd_t    cmd
);

  asrd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asrd_pkg::ST_IDLE: begin
        if (in_valid && sts.slot_free && !sts.imm_done) begin
          state_nxt = sts.is_pull ? asrd_pkg::ST_RDWAIT : asrd_pkg::ST_WRITE;
        end
      end
      asrd_pkg::ST_WRITE: begin
        if (sts.wr_last) begin
          state_nxt = asrd_pkg::ST_IDLE;
        end
      end
      asrd_pkg::ST_RDWAIT: state_nxt = asrd_pkg::ST_IDLE;
      default:             state_nxt = asrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      asrd_pkg::ST_IDLE: begin
        in_stall   = !sts.slot_free;
        cmd.accept = in_valid && sts.slot_free;
        cmd.ld_now = in_valid && sts.slot_free && sts.imm_done;
      end
      asrd_pkg::ST_WRITE: begin
        cmd.wr_step = 1'b1;
        cmd.ld_wr   = sts.wr_last;
      end
      asrd_pkg::ST_RDWAIT: cmd.ld_mem = 1'b1;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/core/asrd_datapath.sv @@
// Datapath of the audio stream ring device: sample store, pointers, count,
// configuration registers and the result register.
// Depends on asrd_pkg; driven by asrd_ctrl through command and status structs.
module asrd_datapath #(
  parameter int unsigned BUF_SIZE = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asrd_pkg::cmd_t              cmd,
  output asrd_pkg::status_t           sts,
  input  logic [1:0]                  in_operation,
  input  logic [15:0]                 in_address,
  input  logic [31:0]                 in_write_data,
  input  logic [2:0]                  in_access_length,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [asrd_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [31:0]                 out_read_data,
  output logic [7:0]                  out_sample_byte,
  output logic                        out_silent,
  output logic                        out_access_error
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int EW = (AW >= 16) ? AW + 1 : 17;

  logic [7:0] mem [BUF_SIZE];

  logic [17:0]   rate_r;
  logic [7:0]    chan_r;
  logic [15:0]   batch_r;
  logic          playing_r, playing_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [31:0]   count_r, count_nxt;

  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [31:0]   wr_data_r, wr_data_nxt;
  logic [2:0]    wr_len_r, wr_len_nxt;
  logic [7:0]    rd_q;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   rdata_r, rdata_nxt;
  logic [7:0]    sbyte_r, sbyte_nxt;
  logic          silent_r, silent_nxt;
  logic          err_r, err_nxt;

  asrd_pkg::op_t op;
  logic [2:0]    len_eff;
  logic          over_end;
  logic          silent_now;
  logic [31:0]   reg_rd;
  logic          pull_rd;

  assign op         = asrd_pkg::op_t'(in_operation);
  assign len_eff    = in_access_length[2] ? 3'd4 : in_access_length;
  // a zero-length write never runs past the end
  assign over_end   = (len_eff != 3'd0) &&
                      ((EW'(in_address) + EW'(len_eff)) > EW'(BUF_SIZE));
  assign silent_now = !playing_r || (count_r == 32'd0);
  assign pull_rd    = cmd.accept && (op == asrd_pkg::OP_PULL) && !silent_now;

  always_comb begin
    case (in_address)
      asrd_pkg::OFF_RATE:  reg_rd = 32'(rate_r);
      asrd_pkg::OFF_CHAN:  reg_rd = 32'(chan_r);
      asrd_pkg::OFF_BATCH: reg_rd = 32'(batch_r);
      asrd_pkg::OFF_SIZE:  reg_rd = 32'(BUF_SIZE);
      asrd_pkg::OFF_COUNT: reg_rd = count_r;
      default:             reg_rd = 32'd0;
    endcase
  end

  always_comb begin
    sts.slot_free = !out_valid_r || !out_stall;
    sts.is_pull   = (op == asrd_pkg::OP_PULL);
    sts.wr_last   = (wr_len_r == 3'd1);
    case (op)
      asrd_pkg::OP_BUF_WR: sts.imm_done = (len_eff == 3'd0) || over_end;
      asrd_pkg::OP_PULL:   sts.imm_done = silent_now;
      default:             sts.imm_done = 1'b1;
    endcase
  end

  // Ring state and write sequencer
  always_comb begin
    playing_nxt = playing_r;
    rp_nxt      = rp_r;
    count_nxt   = count_r;
    wr_addr_nxt = wr_addr_r;
    wr_data_nxt = wr_data_r;
    wr_len_nxt  = wr_len_r;
    if (cmd.accept) begin
      case (op)
        asrd_pkg::OP_REG_WR: begin
          if (in_address == asrd_pkg::OFF_INIT) begin
            playing_nxt = 1'b1;
            rp_nxt      = '0;
            count_nxt   = 32'd0;
          end else if (in_address == asrd_pkg::OFF_COUNT) begin
            count_nxt = in_write_data;
          end
        end
        asrd_pkg::OP_BUF_WR: begin
          if (!over_end && len_eff != 3'd0) begin
            count_nxt   = count_r + 32'(len_eff);
            wr_addr_nxt = AW'(in_address);
            wr_data_nxt = in_write_data;
            wr_len_nxt  = len_eff;
          end
        end
        asrd_pkg::OP_PULL: begin
          if (!silent_now) begin
            rp_nxt    = (rp_r == AW'(BUF_SIZE - 1)) ? '0 : rp_r + AW'(1);
            count_nxt = count_r - 32'd1;
          end
        end
        default: ;
      endcase
    end else if (cmd.wr_step) begin
      // advance to the next byte lane
      wr_addr_nxt = wr_addr_r + AW'(1);
      wr_data_nxt = {8'd0, wr_data_r[31:8]};
      wr_len_nxt  = wr_len_r - 3'd1;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    rdata_nxt     = rdata_r;
    sbyte_nxt     = sbyte_r;
    silent_nxt    = silent_r;
    err_nxt       = err_r;
    if (cmd.ld_now) begin
      out_valid_nxt = 1'b1;
      rdata_nxt     = (op == asrd_pkg::OP_REG_RD) ? reg_rd : 32'd0;
      sbyte_nxt     = 8'd0;
      silent_nxt    = (op == asrd_pkg::OP_PULL);
      err_nxt       = (op == asrd_pkg::OP_BUF_WR) && over_end;
    end else if (cmd.ld_mem || cmd.ld_wr) begin
      out_valid_nxt = 1'b1;
      rdata_nxt     = 32'd0;
      sbyte_nxt     = cmd.ld_mem ? rd_q : 8'd0;
      silent_nxt    = 1'b0;
      err_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r   <= 1'b0;
      rp_r        <= '0;
      count_r     <= 32'd0;
      wr_len_r    <= 3'd0;
      out_valid_r <= 1'b0;
      rate_r      <= 18'd0;
      chan_r      <= 8'd0;
      batch_r     <= 16'd0;
    end else begin
      playing_r   <= playing_nxt;
      rp_r        <= rp_nxt;
      count_r     <= count_nxt;
      wr_len_r    <= wr_len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          asrd_pkg::CFG_RATE:  rate_r  <= cfg_data;
          asrd_pkg::CFG_CHAN:  chan_r  <= cfg_data[7:0];
          asrd_pkg::CFG_BATCH: batch_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    rdata_r   <= rdata_nxt;
    sbyte_r   <= sbyte_nxt;
    silent_r  <= silent_nxt;
    err_r     <= err_nxt;
  end

  // Sample store: at most one byte written and one byte read per cycle; bytes are written only in buffer write steps
  always_ff @(posedge clk) begin
    if (cmd.wr_step) begin
      mem[wr_addr_r] <= wr_data_r[7:0];
    end
    if (pull_rd) begin
      rd_q <= mem[rp_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rdata_r;
  assign out_sample_byte  = sbyte_r;
  assign out_silent       = silent_r;
  assign out_access_error = err_r;

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_now || cmd.ld_mem || cmd.ld_wr) |-> sts.slot_free)
    else $error("result loaded over a word still waiting");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_now, cmd.ld_mem, cmd.ld_wr}))
    else $error("more than one result source selected");

  a_write_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |-> (wr_len_r != 3'd0 && wr_len_r <= 3'd4))
    else $error("byte store with no bytes pending");

  a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rp_r) < 32'(BUF_SIZE))
    else $error("read pointer beyond buffer end");

  a_mem_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_mem |-> $past(pull_rd))
    else $error("store result without a preceding read");

endmodule

@@ test/tb_audio_stream_ring_device.sv @@
// Self-checking bench for the audio stream ring device: register, buffer and
// playback words are checked against an in-bench copy of the ring state.
// Depends on asrd_pkg and audio_stream_ring_device.
module tb_audio_stream_ring_device;

  localparam int unsigned BUF_BYTES   = 65536;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    asrd_pkg::op_t op;
    logic [15:0]   addr;
    logic [31:0]   wdata;
    logic [2:0]    len;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [7:0]  sbyte;
    logic        silent;
    logic        err;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic [2:0]  in_access_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic [7:0]  out_sample_byte;
  logic        out_silent;
  logic        out_access_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [asrd_pkg::CFG_DW-1:0] cfg_data = '0;

  audio_stream_ring_device #(.BUF_SIZE(BUF_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_address(in_address),
    .in_write_data(in_write_data), .in_access_length(in_access_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_sample_byte(out_sample_byte),
    .out_silent(out_silent), .out_access_error(out_access_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bus_word_t    bus_words[$];
  ring_result_t due_results[$];
  bus_word_t    drive_word;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_made = 0;

  // predicted device state
  logic [7:0]  ring_mem [BUF_BYTES];
  logic [15:0] ring_rd_ptr = '0;
  logic [31:0] ring_count = '0;
  logic        ring_playing = 1'b0;
  logic [17:0] cur_rate = '0;
  logic [7:0]  cur_chan = '0;
  logic [15:0] cur_batch = '0;

  // stimulus planning state: keeps pulls off bytes never written
  bit          wr_seen [BUF_BYTES];
  logic [15:0] plan_ptr = '0;
  logic [31:0] plan_count = '0;
  logic        plan_playing = 1'b0;
  int unsigned plan_head = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic ring_result_t run_ring_op(bus_word_t w);
    ring_result_t r;
    int unsigned  l;
    r = '0;
    l = (w.len > 3'd4) ? 4 : int'(w.len);
    case (w.op)
      asrd_pkg::OP_REG_WR: begin
        if (w.addr == asrd_pkg::OFF_INIT) begin
          ring_playing = 1'b1;
          ring_rd_ptr  = '0;
          ring_count   = '0;
        end else if (w.addr == asrd_pkg::OFF_COUNT) begin
          ring_count = w.wdata;
        end
      end
      asrd_pkg::OP_REG_RD: begin
        case (w.addr)
          asrd_pkg::OFF_RATE:  r.rdata = 32'(cur_rate);
          asrd_pkg::OFF_CHAN:  r.rdata = 32'(cur_chan);
          asrd_pkg::OFF_BATCH: r.rdata = 32'(cur_batch);
          asrd_pkg::OFF_SIZE:  r.rdata = BUF_BYTES;
          asrd_pkg::OFF_COUNT: r.rdata = ring_count;
          default:             r.rdata = '0;
        endcase
      end
      asrd_pkg::OP_BUF_WR: begin
        if (l != 0) begin
          if (32'(w.addr) + l > BUF_BYTES) begin
            r.err = 1'b1;
          end else begin
            for (int i = 0; i < int'(l); i++)
              ring_mem[32'(w.addr) + i] = w.wdata[8*i +: 8];
            ring_count += l;
          end
        end
      end
      default: begin
        if (ring_playing && ring_count != 0) begin
          r.sbyte = ring_mem[ring_rd_ptr];
          ring_rd_ptr++;
          ring_count--;
        end else begin
          r.silent = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_word(asrd_pkg::op_t op, logic [15:0] addr, logic [31:0] data,
                            logic [2:0] len);
    int unsigned l;
    bus_word_t   w;
    // steer a pull that would land on an unwritten byte into a fill of that byte
    if (op == asrd_pkg::OP_PULL && plan_playing && plan_count != 0 && !wr_seen[plan_ptr]) begin
      op   = asrd_pkg::OP_BUF_WR;
      addr = plan_ptr;
      len  = (plan_ptr > 16'hFFFB) ? 3'd1 : 3'($urandom_range(1, 4));
    end
    l = (len > 3'd4) ? 4 : int'(len);
    case (op)
      asrd_pkg::OP_REG_WR: begin
        if (addr == asrd_pkg::OFF_INIT) begin
          plan_playing = 1'b1;
          plan_ptr     = '0;
          plan_count   = '0;
          plan_head    = 0;
        end else if (addr == asrd_pkg::OFF_COUNT) begin
          plan_count = data;
        end
      end
      asrd_pkg::OP_BUF_WR: begin
        if (l != 0 && 32'(addr) + l <= BUF_BYTES) begin
          for (int i = 0; i < int'(l); i++) wr_seen[32'(addr) + i] = 1'b1;
          plan_count += l;
        end
      end
      asrd_pkg::OP_PULL: begin
        if (plan_playing && plan_count != 0) begin
          plan_ptr++;
          plan_count--;
        end
      end
      default: ;
    endcase
    w.op    = op;
    w.addr  = addr;
    w.wdata = data;
    w.len   = len;
    bus_words.push_back(w);
    words_made++;
  endtask

  function automatic logic [2:0] pick_len();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 12) return 3'(r % 4 + 1);
    if (r < 14) return 3'd0;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic gen_burst();
    int unsigned pick;
    int unsigned l;
    logic [2:0]  len;
    logic [15:0] addr;
    logic [31:0] data;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // stream: optional restart, a run of writes from the head, pulls, then maybe a count read
      if ($urandom_range(99) < 10)
        queue_word(asrd_pkg::OP_REG_WR, asrd_pkg::OFF_INIT, $urandom, 3'($urandom));
      if ($urandom_range(99) < 3 || plan_head >= BUF_BYTES)
        plan_head = BUF_BYTES - $urandom_range(1, 6);
      repeat ($urandom_range(1, 6)) begin
        len = pick_len();
        l   = (len > 3'd4) ? 4 : int'(len);
        queue_word(asrd_pkg::OP_BUF_WR, 16'(plan_head), $urandom, len);
        if (plan_head + l <= BUF_BYTES) plan_head += l;
      end
      repeat ($urandom_range(1, 12))
        queue_word(asrd_pkg::OP_PULL, 16'($urandom), $urandom, 3'($urandom));
      if ($urandom_range(3) == 0)
        queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_COUNT, $urandom, 3'($urandom));
    end else begin
      case ($urandom_range(4))
        0: addr = asrd_pkg::OFF_RATE;
        1: addr = asrd_pkg::OFF_INIT;
        2: addr = asrd_pkg::OFF_COUNT;
        3: addr = 16'(BUF_BYTES - $urandom_range(1, 8));
        default: addr = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(23));
      endcase
      data = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(40));
      queue_word(asrd_pkg::op_t'($urandom_range(3)), addr, data, 3'($urandom));
    end
  endtask

  task automatic make_traffic(int unsigned n);
    int unsigned target;
    target = words_made + n;
    while (words_made < target) gen_burst();
  endtask

  task automatic wait_drained();
    while (bus_words.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [17:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      asrd_pkg::CFG_RATE:  cur_rate  = val;
      asrd_pkg::CFG_CHAN:  cur_chan  = val[7:0];
      asrd_pkg::CFG_BATCH: cur_batch = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [17:0] rate, logic [17:0] chan, logic [17:0] batch);
    repeat (4) @(posedge clk);
    cfg_write(asrd_pkg::CFG_RATE, rate);
    cfg_write(asrd_pkg::CFG_CHAN, chan);
    cfg_write(asrd_pkg::CFG_BATCH, batch);
  endtask

  // driver: hold a stalled word, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(run_ring_op(drive_word));
      if (!in_valid || !in_stall) begin
        if (bus_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          drive_word = bus_words.pop_front();
          in_valid         <= 1'b1;
          in_operation     <= drive_word.op;
          in_address       <= drive_word.addr;
          in_write_data    <= drive_word.wdata;
          in_access_length <= drive_word.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_read_data, out_sample_byte, out_silent, out_access_error};
      if (due_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result word with nothing outstanding: rd=%h byte=%h silent=%b err=%b",
                   got.rdata, got.sbyte, got.silent, got.err);
      end else begin
        want = due_results.pop_front();
        if (got.rdata !== want.rdata || got.sbyte !== want.sbyte ||
            got.silent !== want.silent || got.err !== want.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: expected rd=%h byte=%h silent=%b err=%b, ",
                      "got rd=%h byte=%h silent=%b err=%b"},
                     want.rdata, want.sbyte, want.silent, want.err,
                     got.rdata, got.sbyte, got.silent, got.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("audio_stream_ring_device test failed");
      $finish;
    end
  end

  initial begin
    tx_idle_pct  = 38;
    rx_stall_pct = 47;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // registers straight out of reset
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_RATE, 32'hFFFF_FFFF, 3'd7);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_CHAN, 32'hFFFF_FFFF, 3'd7);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_BATCH, 32'hFFFF_FFFF, 3'd7);
    wait_drained();
    set_registers(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);

    // not started: silence
    queue_word(asrd_pkg::OP_PULL, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_RATE, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_CHAN, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_BATCH, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_SIZE, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_INIT, 32'h0, 3'd0);
    // unaligned, then unlisted
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_CHAN + 16'd1, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_COUNT + 16'd4, 32'h0, 3'd0);
    // bus cannot change these
    queue_word(asrd_pkg::OP_REG_WR, asrd_pkg::OFF_RATE, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_WR, asrd_pkg::OFF_SIZE, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_RATE, 32'h0, 3'd0);
    // counted before start
    queue_word(asrd_pkg::OP_BUF_WR, 16'h0000, 32'hDEAD_BEEF, 3'd4);
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_REG_WR, asrd_pkg::OFF_INIT, 32'hFFFF_FFFF, 3'd7);
    // empty: silence
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_BUF_WR, 16'h0000, 32'h0403_0201, 3'd4);
    // zero length, then overlong taken as four
    queue_word(asrd_pkg::OP_BUF_WR, 16'h0004, 32'hFFFF_FFFF, 3'd0);
    queue_word(asrd_pkg::OP_BUF_WR, 16'h0004, 32'h8877_6655, 3'd7);
    // runs past the end, then ends exactly at the end
    queue_word(asrd_pkg::OP_BUF_WR, 16'hFFFE, 32'hA5A5_A5A5, 3'd4);
    queue_word(asrd_pkg::OP_BUF_WR, 16'hFFFC, 32'h5A5A_5A5A, 3'd4);
    queue_word(asrd_pkg::OP_BUF_WR, 16'hFFFF, 32'h0000_00C3, 3'd1);
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    // count wraps to one
    queue_word(asrd_pkg::OP_REG_WR, asrd_pkg::OFF_COUNT, 32'hFFFF_FFFF, 3'd0);
    queue_word(asrd_pkg::OP_BUF_WR, 16'h0008, 32'h0000_7E81, 3'd2);
    queue_word(asrd_pkg::OP_REG_RD, asrd_pkg::OFF_COUNT, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    queue_word(asrd_pkg::OP_PULL, 16'h0, 32'h0, 3'd0);
    wait_drained();

    set_registers(18'($urandom), 18'($urandom), 18'($urandom));
    make_traffic(255);
    wait_drained();                                           // sender pauses here
    make_traffic(255);
    wait_drained();

    tx_idle_pct  = 47;
    rx_stall_pct = 38;
    set_registers(18'h0, 18'h0, 18'h0);
    make_traffic(510);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_registers(18'($urandom), 18'($urandom), 18'($urandom));
    make_traffic(510);
    hold_req = hold_req + 1;                                  // fill the block, then release
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("audio_stream_ring_device test passed");
    end else begin
      $display("audio_stream_ring_device test failed");
    end
    $finish;
  end

endmodule
